>>> sv/block_map_allocator_assert.svh
// Assertion macros for the block map allocator checker.
// No dependencies; taken in by the checker module.
`ifndef BLOCK_MAP_ALLOCATOR_ASSERT_SVH
`define BLOCK_MAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define BMA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BMA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> sv/bma_pkg.sv
// Shared types and constants of the block map allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bma_pkg;

	localparam int unsigned DEF_BLOCK_BYTES = 128;
	localparam int unsigned DEF_POOL_BYTES  = 32 * 1024;

	typedef enum logic [1:0] {
		OP_ALLOC = 2'd0,
		OP_FREE  = 2'd1,
		OP_CLEAR = 2'd2,
		OP_NOP   = 2'd3
	} bma_op_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_ZERO    = 2'd1,
		ST_NOSPACE = 2'd2,
		ST_RANGE   = 2'd3
	} bma_status_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_DECODE,
		S_SCAN,
		S_MARK,
		S_FREE_RD,
		S_FREE_LD,
		S_FREE_CLR,
		S_WIPE,
		S_DONE
	} bma_state_t;

	typedef struct packed {
		logic        load;
		logic        scan_start;
		logic        scan_step;
		logic        free_read;
		logic        free_load;
		logic        wr_step;
		logic        wr_need;
		logic        wipe_start;
		logic        grant;
		logic        set_err;
		bma_status_t err;
	} bma_cmd_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic       req_zero;
		logic       off_range;
		logic       scan_hit;
		logic       scan_fail;
		logic       rd_zero;
		logic       cnt_last;
		logic       ptr_last;
	} bma_sts_t;

endpackage

>>> sv/bma_datapath.sv
// Datapath of the block map allocator: block table memory, scan and write pointers,
// run tracking and result registers. Depends on bma_pkg.
`timescale 1ns / 1ps

module bma_datapath import bma_pkg::*; #(
	parameter int unsigned BLOCK_BYTES = DEF_BLOCK_BYTES,
	parameter int unsigned POOL_BYTES  = DEF_POOL_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  opcode,
	input  logic [15:0] request_bytes,
	input  logic [15:0] free_offset,
	input  bma_cmd_t    cmd,
	output bma_sts_t    sts,
	output logic [1:0]  status,
	output logic [14:0] granted_offset
);

	localparam int unsigned NUM_BLOCKS = POOL_BYTES / BLOCK_BYTES;
	localparam int unsigned IDX_W      = $clog2(NUM_BLOCKS);
	localparam int unsigned CNT_W      = $clog2(NUM_BLOCKS + 1);
	localparam int unsigned RB_W       = $clog2(POOL_BYTES + BLOCK_BYTES + 1);
	localparam int unsigned CMP_W      = (RB_W > 16) ? RB_W : 16;
	localparam int unsigned RECIP_SH   = 16 + $clog2(BLOCK_BYTES);
	localparam longint unsigned RECIP_M =
		((64'd1 << RECIP_SH) + BLOCK_BYTES - 1) / BLOCK_BYTES;
	localparam int unsigned PROD_W     = RECIP_SH + IDX_W;
	localparam int unsigned GR_RAW     = IDX_W + $clog2(BLOCK_BYTES + 1);
	localparam int unsigned GR_W       = (GR_RAW > 15) ? GR_RAW : 15;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BLOCKS - 1);

	logic [CNT_W-1:0]  mem_q [NUM_BLOCKS];
	logic [CNT_W-1:0]  rdata_q;

	logic [1:0]        opcode_q;
	logic [15:0]       bytes_q;
	logic [15:0]       offset_q;
	logic [IDX_W-1:0]  blk_q;
	logic [IDX_W-1:0]  ptr_q;
	logic              iss_q;
	logic              rv_s1;
	logic [IDX_W-1:0]  ridx_s1;
	logic [CNT_W-1:0]  run_q;
	logic [CMP_W-1:0]  rb_q;
	logic [CNT_W-1:0]  need_q;
	logic [IDX_W-1:0]  base_q;
	logic [IDX_W-1:0]  wptr_q;
	logic [CNT_W-1:0]  cnt_q;
	bma_status_t       st_q;
	logic [14:0]       gr_q;

	logic              we;
	logic              re;
	logic [IDX_W-1:0]  raddr;
	logic [CNT_W-1:0]  wdata;
	logic              free_e;
	logic [CNT_W-1:0]  run_nx;
	logic [CMP_W-1:0]  rb_nx;
	logic              hit;
	logic              fail;
	logic [PROD_W-1:0] prod;
	logic [GR_W-1:0]   gr_prod;

	// offset / BLOCK_BYTES by reciprocal; exact for every offset inside the pool
	assign prod    = PROD_W'(offset_q) * PROD_W'(RECIP_M);
	assign gr_prod = GR_W'(base_q) * GR_W'(BLOCK_BYTES);

	assign free_e = (rdata_q == '0);
	assign run_nx = run_q + CNT_W'(1);
	assign rb_nx  = rb_q + CMP_W'(BLOCK_BYTES);
	assign hit    = rv_s1 && free_e && (rb_nx >= CMP_W'(bytes_q));
	assign fail   = rv_s1 && !hit && (ridx_s1 == '0);

	assign we    = cmd.wr_step;
	assign wdata = cmd.wr_need ? need_q : '0;
	assign re    = cmd.scan_step ? iss_q : cmd.free_read;
	assign raddr = cmd.scan_step ? ptr_q : blk_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wptr_q] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q  <= 1'b0;
			rv_s1  <= 1'b0;
			wptr_q <= '0;
		end else begin
			if (cmd.scan_start) begin
				iss_q <= 1'b1;
				rv_s1 <= 1'b0;
			end else if (cmd.scan_step) begin
				rv_s1 <= iss_q;
				if (iss_q && ptr_q == '0) begin
					iss_q <= 1'b0;
				end
			end
			if (cmd.wipe_start) begin
				wptr_q <= '0;
			end else if (cmd.scan_step && hit) begin
				wptr_q <= ridx_s1;
			end else if (cmd.free_load) begin
				wptr_q <= blk_q;
			end else if (cmd.wr_step) begin
				wptr_q <= wptr_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		blk_q <= prod[RECIP_SH +: IDX_W];
		if (cmd.load) begin
			opcode_q <= opcode;
			bytes_q  <= request_bytes;
			offset_q <= free_offset;
			st_q     <= ST_OK;
			gr_q     <= '0;
		end
		if (cmd.set_err) begin
			st_q <= cmd.err;
		end
		if (cmd.grant) begin
			gr_q <= gr_prod[14:0];
		end
		if (cmd.scan_start) begin
			ptr_q <= LAST_IDX;
			run_q <= '0;
			rb_q  <= '0;
		end else if (cmd.scan_step) begin
			if (iss_q && ptr_q != '0) begin
				ptr_q <= ptr_q - IDX_W'(1);
			end
			ridx_s1 <= ptr_q;
			if (rv_s1) begin
				run_q <= free_e ? run_nx : '0;
				rb_q  <= free_e ? rb_nx : '0;
			end
			if (hit) begin
				base_q <= ridx_s1;
				need_q <= run_nx;
				cnt_q  <= run_nx;
			end
		end else if (cmd.free_load) begin
			cnt_q <= rdata_q;
		end else if (cmd.wr_step) begin
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	assign sts.opcode    = opcode_q;
	assign sts.req_zero  = (bytes_q == '0);
	assign sts.off_range = (CMP_W'(offset_q) >= CMP_W'(POOL_BYTES));
	assign sts.scan_hit  = hit;
	assign sts.scan_fail = fail;
	assign sts.rd_zero   = free_e;
	assign sts.cnt_last  = (cnt_q == CNT_W'(1));
	assign sts.ptr_last  = (wptr_q == LAST_IDX);

	assign status         = st_q;
	assign granted_offset = gr_q;

endmodule

>>> sv/bma_ctrl.sv
// Controller state machine of the block map allocator: sequences decode, scan,
// mark, free and table wipe, and drives the datapath commands. Depends on bma_pkg.
`timescale 1ns / 1ps

module bma_ctrl import bma_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  bma_sts_t sts,
	output bma_cmd_t cmd,
	output logic     busy,
	output logic     done
);

	bma_state_t state_q;
	bma_state_t state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_INIT: begin
				if (sts.ptr_last) state_nx = S_IDLE;
			end
			S_IDLE: begin
				if (start) state_nx = S_DECODE;
			end
			S_DECODE: begin
				unique case (sts.opcode)
					OP_ALLOC: state_nx = sts.req_zero ? S_DONE : S_SCAN;
					OP_FREE:  state_nx = sts.off_range ? S_DONE : S_FREE_RD;
					OP_CLEAR: state_nx = S_WIPE;
					default:  state_nx = S_DONE;
				endcase
			end
			S_SCAN: begin
				if (sts.scan_hit) begin
					state_nx = S_MARK;
				end else if (sts.scan_fail) begin
					state_nx = S_DONE;
				end
			end
			S_MARK: begin
				if (sts.cnt_last) state_nx = S_DONE;
			end
			S_FREE_RD: state_nx = S_FREE_LD;
			S_FREE_LD: state_nx = sts.rd_zero ? S_DONE : S_FREE_CLR;
			S_FREE_CLR: begin
				if (sts.cnt_last || sts.ptr_last) state_nx = S_DONE;
			end
			S_WIPE: begin
				if (sts.ptr_last) state_nx = S_DONE;
			end
			S_DONE:  state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		cmd.err = ST_OK;
		busy = (state_q != S_IDLE);
		done = 1'b0;
		unique case (state_q)
			S_INIT: cmd.wr_step = 1'b1;
			S_IDLE: cmd.load = start;
			S_DECODE: begin
				unique case (sts.opcode)
					OP_ALLOC: begin
						if (sts.req_zero) begin
							cmd.set_err = 1'b1;
							cmd.err     = ST_ZERO;
						end else begin
							cmd.scan_start = 1'b1;
						end
					end
					OP_FREE: begin
						if (sts.off_range) begin
							cmd.set_err = 1'b1;
							cmd.err     = ST_RANGE;
						end
					end
					OP_CLEAR: cmd.wipe_start = 1'b1;
					default: ;
				endcase
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (!sts.scan_hit && sts.scan_fail) begin
					cmd.set_err = 1'b1;
					cmd.err     = ST_NOSPACE;
				end
			end
			S_MARK: begin
				cmd.wr_step = 1'b1;
				cmd.wr_need = 1'b1;
				cmd.grant   = 1'b1;
			end
			S_FREE_RD:  cmd.free_read = 1'b1;
			S_FREE_LD:  cmd.free_load = 1'b1;
			S_FREE_CLR: cmd.wr_step   = 1'b1;
			S_WIPE:     cmd.wr_step   = 1'b1;
			S_DONE:     done          = 1'b1;
			default: ;
		endcase
	end

endmodule

>>> sv/block_map_allocator.sv
// Top level of the block map allocator: controller and datapath.
// Depends on bma_pkg, bma_ctrl and bma_datapath.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------------
//  request  | start, busy          | opcode, request_bytes, free_offset
//  result   | done (1-cycle strobe)| status, granted_offset
//
// A transfer is taken when start is high and busy is low; each gives one result.
// States after acceptance, each ending in done: allocate decodes, scans (one
// table read a cycle) and marks the run; free decodes, reads, loads and clears;
// clear decodes and wipes the table; an error or an unused opcode only decodes.
// busy falls the cycle after done, so the next transfer can be taken in that cycle.
// After reset the table is wiped with busy held high.
// The receiver cannot stall; done marks a result for exactly one cycle.
`timescale 1ns / 1ps

module block_map_allocator import bma_pkg::*; #(
	parameter int unsigned BLOCK_BYTES = DEF_BLOCK_BYTES,
	parameter int unsigned POOL_BYTES  = DEF_POOL_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  opcode,
	input  logic [15:0] request_bytes,
	input  logic [15:0] free_offset,
	output logic        done,
	output logic [1:0]  status,
	output logic [14:0] granted_offset
);

	bma_cmd_t cmd;
	bma_sts_t sts;

	bma_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	bma_datapath #(
		.BLOCK_BYTES (BLOCK_BYTES),
		.POOL_BYTES  (POOL_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.opcode         (opcode),
		.request_bytes  (request_bytes),
		.free_offset    (free_offset),
		.cmd            (cmd),
		.sts            (sts),
		.status         (status),
		.granted_offset (granted_offset)
	);

endmodule

>>> sv/bma_checker.sv
// Port-level checker for the block map allocator, bound to the top level.
// Depends on bma_pkg and block_map_allocator_assert.svh.
`timescale 1ns / 1ps

`include "block_map_allocator_assert.svh"

module bma_checker import bma_pkg::*; (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic [14:0] granted_offset
);

	`BMA_ASSERT_NOW(a_done_busy, clk, arst_n, done, busy, "result outside a transfer")
	`BMA_ASSERT_NEXT(a_take_busy, clk, arst_n, start && !busy, busy && !done, "transfer not taken")
	`BMA_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done && !busy, "strobe longer than a cycle")
	`BMA_ASSERT_NOW(a_err_zero, clk, arst_n, done && status != ST_OK, granted_offset == '0, "offset on error")

endmodule

bind block_map_allocator bma_checker u_bma_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.status         (status),
	.granted_offset (granted_offset)
);

>>> dv/block_map_allocator_tb.sv
// Self-checking testbench for block_map_allocator: directed and random requests,
// each predicted from a block-table model in a scoreboard. Depends on bma_pkg.
`timescale 1ns / 1ps

module block_map_allocator_tb;
	import bma_pkg::*;

	localparam int unsigned NUM_BLOCKS = DEF_POOL_BYTES / DEF_BLOCK_BYTES;
	localparam int unsigned DRAIN_CYCLES = 2 * NUM_BLOCKS + 16;

	typedef struct packed {
		bma_status_t st;
		logic [14:0] offset;
	} grant_t;

	class alloc_table_scoreboard;
		logic [8:0]  owner_count [NUM_BLOCKS];
		grant_t      expected_grants [$];
		logic [15:0] live_offsets [$];
		int          errors;

		function new();
			errors = 0;
			wipe_table();
		endfunction

		function void wipe_table();
			foreach (owner_count[i])
				owner_count[i] = '0;
			live_offsets.delete();
		endfunction

		function int pending();
			return expected_grants.size();
		endfunction

		function logic [15:0] pick_live();
			if (live_offsets.size() == 0)
				return 16'($urandom_range(DEF_POOL_BYTES - 1, 0));
			return live_offsets[$urandom_range(live_offsets.size() - 1, 0)];
		endfunction

		// one transfer accepted: update the table and queue its result
		function void note_request(logic [1:0] op, logic [15:0] nbytes, logic [15:0] off);
			grant_t g;
			int unsigned need;
			int unsigned run;
			int unsigned idx;
			int unsigned cnt;
			bit hit;
			g.st = ST_OK;
			g.offset = '0;
			case (op)
				OP_ALLOC: begin
					if (nbytes == 0) begin
						g.st = ST_ZERO;
					end else begin
						need = (int'(nbytes) + DEF_BLOCK_BYTES - 1) / DEF_BLOCK_BYTES;
						run = 0;
						hit = 0;
						if (need <= NUM_BLOCKS) begin
							for (int i = NUM_BLOCKS - 1; i >= 0 && !hit; i--) begin
								run = (owner_count[i] == 0) ? run + 1 : 0;
								if (run == need) begin
									hit = 1;
									idx = i;
								end
							end
						end
						if (hit) begin
							for (int k = 0; k < need; k++)
								owner_count[idx + k] = 9'(need);
							g.offset = 15'(idx * DEF_BLOCK_BYTES);
							live_offsets.push_back(16'(idx * DEF_BLOCK_BYTES));
						end else begin
							g.st = ST_NOSPACE;
						end
					end
				end
				OP_FREE: begin
					if (off >= DEF_POOL_BYTES) begin
						g.st = ST_RANGE;
					end else begin
						idx = off / DEF_BLOCK_BYTES;
						cnt = owner_count[idx];
						for (int k = 0; k < cnt && idx + k < NUM_BLOCKS; k++)
							owner_count[idx + k] = '0;
						foreach (live_offsets[i])
							if (live_offsets[i] == off) begin
								live_offsets.delete(i);
								break;
							end
					end
				end
				OP_CLEAR: wipe_table();
				default: ;
			endcase
			expected_grants.push_back(g);
		endfunction

		function void check_result(logic [1:0] st, logic [14:0] offset);
			grant_t g;
			if (expected_grants.size() == 0) begin
				$display("%0t: unexpected result, status %0d offset %0d", $time, st, offset);
				errors++;
				return;
			end
			g = expected_grants.pop_front();
			if (st !== g.st) begin
				$display("%0t: status expected %0d actual %0d", $time, g.st, st);
				errors++;
			end
			if (offset !== g.offset) begin
				$display("%0t: granted_offset expected %0d actual %0d",
					$time, g.offset, offset);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [1:0]  opcode;
	logic [15:0] request_bytes;
	logic [15:0] free_offset;
	logic        done;
	logic [1:0]  status;
	logic [14:0] granted_offset;

	alloc_table_scoreboard sb;

	block_map_allocator dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.opcode         (opcode),
		.request_bytes  (request_bytes),
		.free_offset    (free_offset),
		.done           (done),
		.status         (status),
		.granted_offset (granted_offset)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check_result(status, granted_offset);
	end

	// sender idles for a random number of cycles with the given percentage
	task automatic sender_gap(input int pct);
		if ($urandom_range(99, 0) < pct) begin
			start <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99, 0) < pct);
		end
	endtask

	task automatic send_item(input logic [1:0] op, input logic [15:0] nbytes,
			input logic [15:0] off);
		start         <= 1'b1;
		opcode        <= op;
		request_bytes <= nbytes;
		free_offset   <= off;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		sb.note_request(op, nbytes, off);
	endtask

	task automatic run_random(input int count, input int pct);
		int sel;
		int r;
		logic [1:0]  op;
		logic [15:0] nbytes;
		logic [15:0] off;
		for (int i = 0; i < count; i++) begin
			sel    = $urandom_range(99, 0);
			r      = $urandom_range(99, 0);
			nbytes = 16'($urandom);
			off    = 16'($urandom);
			if (sel < 45) begin
				op = OP_ALLOC;
				if (r < 70)
					nbytes = 16'($urandom_range(1024, 1));
				else if (r < 93)
					nbytes = 16'($urandom_range(8192, 1));
			end else if (sel < 87) begin
				op = OP_FREE;
				if (r < 65)
					off = sb.pick_live();
				else if (r < 85)
					off = sb.pick_live() + 16'($urandom_range(511, 0));
			end else if (sel < 91) begin
				op = OP_CLEAR;
			end else if (sel < 95) begin
				op = OP_NOP;
			end else begin
				op = 2'($urandom_range(1, 0));
			end
			sender_gap(pct);
			send_item(op, nbytes, off);
		end
	endtask

	initial begin
		sb            = new();
		clk           = 1'b0;
		arst_n        = 1'b0;
		start         = 1'b0;
		opcode        = '0;
		request_bytes = '0;
		free_offset   = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		send_item(OP_CLEAR, 16'd0, 16'd0);
		send_item(OP_ALLOC, 16'd0, 16'hFFFF);
		send_item(OP_ALLOC, 16'd1, 16'd0);
		send_item(OP_ALLOC, 16'd128, 16'd0);
		send_item(OP_ALLOC, 16'd129, 16'd0);
		send_item(OP_ALLOC, 16'hFFFF, 16'd0);
		send_item(OP_ALLOC, 16'd32769, 16'd0);
		send_item(OP_FREE, 16'd0, 16'd32640);
		send_item(OP_FREE, 16'd0, 16'd32520);
		send_item(OP_FREE, 16'd0, 16'd0);
		send_item(OP_FREE, 16'd0, 16'd32768);
		send_item(OP_FREE, 16'hFFFF, 16'hFFFF);
		send_item(OP_FREE, 16'd0, 16'd32767);
		send_item(OP_CLEAR, 16'hFFFF, 16'hFFFF);
		send_item(OP_ALLOC, 16'd384, 16'd0);
		send_item(OP_FREE, 16'd0, 16'd32512);
		send_item(OP_FREE, 16'd0, 16'd32384);
		send_item(OP_ALLOC, 16'd32768, 16'd0);
		send_item(OP_ALLOC, 16'd1, 16'd0);
		send_item(OP_NOP, 16'hFFFF, 16'hFFFF);
		send_item(OP_FREE, 16'd0, 16'd0);
		send_item(OP_ALLOC, 16'd32768, 16'd0);
		send_item(OP_CLEAR, 16'd0, 16'd0);
		send_item(OP_NOP, 16'd0, 16'd0);

		run_random(630, 17);
		run_random(630, 54);
		run_random(630, 0);
		start <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.errors == 0)
			$display("** block_map_allocator: PASSED **");
		else
			$display("** block_map_allocator: FAILED **");
		$finish;
	end

	initial begin
		#60ms;
		$display("** block_map_allocator: FAILED **");
		$finish;
	end

endmodule
